// ===== rtl/core/dtq_pkg.sv =====
// ----------------------------------------------------------------------------
// dtq_pkg: shared types and constants of the deadline timer queue
// Table size, field widths, operation and status codes, and the command and
// status groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package dtq_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int TIME_BITS   = 32;
  localparam int MAX_RESULTS = 16;

  // Port field widths
  localparam int OP_W     = 2;
  localparam int DL_W     = 32;
  localparam int OWNER_W  = 8;
  localparam int STATUS_W = 3;

  // Stored time width: ticks are taken modulo 2^TIME_BITS, ports carry 32 bits
  localparam int TIME_W = (TIME_BITS < DL_W) ? TIME_BITS : DL_W;

  // Fired-result counter, able to hold MAX_RESULTS itself
  localparam int CNT_W = $clog2(MAX_RESULTS + 1);

  // Operation codes
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_CANCEL = 2'd1;
  localparam logic [OP_W-1:0] OP_CHECK  = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_CANCELLED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FIRED     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NOTHING   = 3'd5;

  // Controller -> datapath
  typedef struct packed {
    logic                load_req;    // capture the request on transfer
    logic                insert;      // sorted insert of the request
    logic                cancel;      // kill the first live match
    logic                pop;         // drop the front entry, shift down
    logic                emit;        // load the output register
    logic [STATUS_W-1:0] emit_status;
    logic                emit_last;
  } dtq_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            full;        // every slot occupied
    logic            cancel_hit;  // a live entry matches the cancel
    logic            front_due;   // front slot occupied and due
    logic            front_live;  // front slot not cancelled
    logic            more_due;    // a live due entry sits behind the front
  } dtq_sts_t;

endpackage

// ===== rtl/core/dtq_datapath.sv =====
// ----------------------------------------------------------------------------
// dtq_datapath: timer table, request register and output register
// Sorted slot array with parallel compare, shift-up insert, shift-down pop,
// and lowest-match cancel.
// ----------------------------------------------------------------------------
module dtq_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  dtq_pkg::dtq_cmd_t                 cmd,
  output dtq_pkg::dtq_sts_t                 sts,
  input  logic [dtq_pkg::OP_W-1:0]          in_operation,
  input  logic [dtq_pkg::DL_W-1:0]          in_deadline,
  input  logic [dtq_pkg::DL_W-1:0]          in_current_tick,
  input  logic [dtq_pkg::OWNER_W-1:0]       in_owner_id,
  output logic [dtq_pkg::STATUS_W-1:0]      out_status,
  output logic [dtq_pkg::OWNER_W-1:0]       out_fired_owner,
  output logic [dtq_pkg::DL_W-1:0]          out_fired_deadline,
  output logic                              out_last_result
);
  import dtq_pkg::*;

  logic [TIME_W-1:0]      slot_dl_r    [TABLE_DEPTH];
  logic [OWNER_W-1:0]     slot_owner_r [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] slot_occ_r;
  logic [TABLE_DEPTH-1:0] slot_live_r;

  logic [OP_W-1:0]        req_op_r;
  logic [TIME_W-1:0]      req_dl_r;
  logic [TIME_W-1:0]      req_tick_r;
  logic [OWNER_W-1:0]     req_owner_r;

  logic [STATUS_W-1:0]    out_status_r;
  logic [OWNER_W-1:0]     out_owner_r;
  logic [DL_W-1:0]        out_dl_r;
  logic                   out_last_r;

  logic [TABLE_DEPTH-1:0] gt;      // slot deadline beyond request deadline
  logic [TABLE_DEPTH-1:0] due;     // slot deadline at or below tick
  logic [TABLE_DEPTH-1:0] hit;     // live match for cancel
  logic [TABLE_DEPTH-1:0] hit_first;

  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      gt[i]  = slot_occ_r[i] && (slot_dl_r[i] > req_dl_r);
      due[i] = slot_occ_r[i] && (slot_dl_r[i] <= req_tick_r);
      hit[i] = slot_occ_r[i] && slot_live_r[i] && (slot_dl_r[i] == req_dl_r) &&
               (slot_owner_r[i] == req_owner_r);
    end
    hit_first = hit & (~hit + TABLE_DEPTH'(1));
  end

  assign sts.op         = req_op_r;
  assign sts.full       = slot_occ_r[TABLE_DEPTH-1];
  assign sts.cancel_hit = |hit;
  assign sts.front_due  = due[0];
  assign sts.front_live = slot_live_r[0];
  assign sts.more_due   = |(due[TABLE_DEPTH-1:1] & slot_live_r[TABLE_DEPTH-1:1]);

  // Request capture
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_op_r    <= in_operation;
      req_dl_r    <= TIME_W'(in_deadline);
      req_tick_r  <= TIME_W'(in_current_tick);
      req_owner_r <= in_owner_id;
    end
  end

  // Slot table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_occ_r  <= '0;
      slot_live_r <= '0;
    end else if (cmd.insert) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (i > 0 && gt[i-1]) begin
          slot_occ_r[i]  <= slot_occ_r[i-1];
          slot_live_r[i] <= slot_live_r[i-1];
        end else if ((!slot_occ_r[i] || gt[i]) &&
                     (i == 0 || slot_occ_r[i-1])) begin
          slot_occ_r[i]  <= 1'b1;
          slot_live_r[i] <= 1'b1;
        end
      end
    end else if (cmd.cancel) begin
      slot_live_r <= slot_live_r & ~hit_first;
    end else if (cmd.pop) begin
      slot_occ_r  <= {1'b0, slot_occ_r[TABLE_DEPTH-1:1]};
      slot_live_r <= {1'b0, slot_live_r[TABLE_DEPTH-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (i > 0 && gt[i-1]) begin
          slot_dl_r[i]    <= slot_dl_r[i-1];
          slot_owner_r[i] <= slot_owner_r[i-1];
        end else if ((!slot_occ_r[i] || gt[i]) &&
                     (i == 0 || slot_occ_r[i-1])) begin
          slot_dl_r[i]    <= req_dl_r;
          slot_owner_r[i] <= req_owner_r;
        end
      end
    end else if (cmd.pop) begin
      for (int i = 0; i < TABLE_DEPTH - 1; i++) begin
        slot_dl_r[i]    <= slot_dl_r[i+1];
        slot_owner_r[i] <= slot_owner_r[i+1];
      end
    end
  end

  // Output register: fired results carry the front entry, others echo
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status_r <= cmd.emit_status;
      out_last_r   <= cmd.emit_last;
      if (cmd.emit_status == ST_FIRED) begin
        out_owner_r <= slot_owner_r[0];
        out_dl_r    <= DL_W'(slot_dl_r[0]);
      end else begin
        out_owner_r <= req_owner_r;
        out_dl_r    <= DL_W'(req_dl_r);
      end
    end
  end

  assign out_status         = out_status_r;
  assign out_fired_owner    = out_owner_r;
  assign out_fired_deadline = out_dl_r;
  assign out_last_result    = out_last_r;

endmodule

// ===== rtl/core/dtq_ctrl.sv =====
// ----------------------------------------------------------------------------
// dtq_ctrl: sequencing of one request through the datapath
// Two-state machine, fired-result count and output valid flag.
// ----------------------------------------------------------------------------
module dtq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output dtq_pkg::dtq_cmd_t cmd,
  input  dtq_pkg::dtq_sts_t sts
);
  import dtq_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic             state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;
  logic             cap;

  assign out_free = !out_valid_r || out_ready;
  assign cap      = (cnt_r == CNT_W'(MAX_RESULTS));

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    in_ready      = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_req = 1'b1;
          cnt_nxt      = '0;
          state_nxt    = S_EXEC;
        end
      end
      S_EXEC: begin
        case (sts.op)
          OP_INSERT: begin
            if (out_free) begin
              cmd.insert      = !sts.full;
              cmd.emit        = 1'b1;
              cmd.emit_status = sts.full ? ST_FULL : ST_INSERTED;
              cmd.emit_last   = 1'b1;
              state_nxt       = S_IDLE;
            end
          end
          OP_CANCEL: begin
            if (out_free) begin
              cmd.cancel      = sts.cancel_hit;
              cmd.emit        = 1'b1;
              cmd.emit_status = sts.cancel_hit ? ST_CANCELLED : ST_NOT_FOUND;
              cmd.emit_last   = 1'b1;
              state_nxt       = S_IDLE;
            end
          end
          OP_CHECK: begin
            if (sts.front_due && !(sts.front_live && cap)) begin
              if (!sts.front_live) begin
                cmd.pop = 1'b1;  // dead entry leaves silently
              end else if (out_free) begin
                cmd.pop         = 1'b1;
                cmd.emit        = 1'b1;
                cmd.emit_status = ST_FIRED;
                cmd.emit_last   = !sts.more_due ||
                                  (cnt_r == CNT_W'(MAX_RESULTS - 1));
                cnt_nxt         = cnt_r + CNT_W'(1);
              end
            end else if (cnt_r != '0) begin
              state_nxt = S_IDLE;
            end else if (out_free) begin
              cmd.emit        = 1'b1;
              cmd.emit_status = ST_NOTHING;
              cmd.emit_last   = 1'b1;
              state_nxt       = S_IDLE;
            end
          end
          default: state_nxt = S_IDLE;  // unused code: no result
        endcase
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== rtl/core/deadline_timer_queue.sv =====
// ----------------------------------------------------------------------------
// deadline_timer_queue: sorted timer queue
// Holds up to TABLE_DEPTH (deadline, owner) timers sorted by deadline, ties
// in insertion order. Insert, cancel (marks dead) and check (pops all due
// entries, firing the live ones) requests.
//
//   Channel  Direction  Handshake            Payload
//   in_      input      in_valid/in_ready    operation, deadline,
//                                            current_tick, owner_id
//   out_     output     out_valid/out_ready  status, fired_owner,
//                                            fired_deadline, last_result
//
// Sequencing: a request is captured on transfer, then executed; insert and
//   cancel each emit one result. A check pops one front entry per cycle,
//   a dead one freely, a live one only when the output register is free.
// Reset: rst_n clears occupancy, live flags, state and out_valid; no sweep.
// Stalls: the output register holds one result; execution waits while it
//   is full and not being taken. One request in flight at a time.
// ----------------------------------------------------------------------------
module deadline_timer_queue (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [dtq_pkg::OP_W-1:0]     in_operation,
  input  logic [dtq_pkg::DL_W-1:0]     in_deadline,
  input  logic [dtq_pkg::DL_W-1:0]     in_current_tick,
  input  logic [dtq_pkg::OWNER_W-1:0]  in_owner_id,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [dtq_pkg::STATUS_W-1:0] out_status,
  output logic [dtq_pkg::OWNER_W-1:0]  out_fired_owner,
  output logic [dtq_pkg::DL_W-1:0]     out_fired_deadline,
  output logic                         out_last_result
);
  import dtq_pkg::*;

  dtq_cmd_t cmd;  // controller commands to the datapath
  dtq_sts_t sts;  // table and request status back to the controller

  // Sequencer: request capture, per-op execution, check pop loop
  dtq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Table, request and output registers
  dtq_datapath u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_operation       (in_operation),
    .in_deadline        (in_deadline),
    .in_current_tick    (in_current_tick),
    .in_owner_id        (in_owner_id),
    .out_status         (out_status),
    .out_fired_owner    (out_fired_owner),
    .out_fired_deadline (out_fired_deadline),
    .out_last_result    (out_last_result)
  );

endmodule
